### hw/rtl/anbs_pkg.sv
// Shared types and constants of the Annex B NAL splitter.
package anbs_pkg;

   localparam int DEF_MAX_UNIT_BYTES = 1024 * 1024;
   localparam int LEN_W              = 21;
   localparam logic [LEN_W-1:0] LEN_FIELD_MAX = {LEN_W{1'b1}};
   localparam int HOLD_DEPTH         = 4;
   localparam int MAX_EMITS          = 5;
   localparam int QUEUE_DEPTH        = 8;
   localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);
   localparam logic [7:0] START_TAIL = 8'h01;

   typedef struct packed {
      logic [7:0]       nal_byte;
      logic             nal_first;
      logic             nal_last;
      logic [LEN_W-1:0] nal_length;
      logic             length_overflow;
   } result_type;

   typedef struct packed {
      logic [2:0]                     count;
      result_type [MAX_EMITS-1:0]     item;
   } push_type;

endpackage

### hw/rtl/anbs_ifs.sv
// Valid/ready channel interfaces for the byte input and the NAL result output.
interface anbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface anbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  nal_byte;
   logic        nal_first;
   logic        nal_last;
   logic [20:0] nal_length;
   logic        length_overflow;

   modport source (output valid, output nal_byte, output nal_first, output nal_last,
                   output nal_length, output length_overflow, input ready);
   modport sink   (input valid, input nal_byte, input nal_first, input nal_last,
                   input nal_length, input length_overflow, output ready);
endinterface

### hw/rtl/annexb_nal_splitter.sv
// Top level of the H.264 Annex B start code NAL unit splitter.
// Usage:
//   req_ch carries one byte of an encoded frame per word, with frame_end set on
//   the frame's last byte. rsp_ch delivers the payload bytes of each NAL unit,
//   first and last marked, the unit length on the last byte (saturating at
//   MAX_UNIT_BYTES, with length_overflow set once the unit runs past it).
//   Start codes 00 00 01 and 00 00 00 01 are removed, bytes before the first
//   start code of a frame are discarded and empty units give no words.
// Timing:
//   A byte is registered on acceptance; the words it releases are registered in
//   the result queue as it is parsed. Up to four bytes are held in the start
//   code window before release. Sustained rate is one byte per cycle while the
//   queue has room; a frame end flushes up to five words, drained one per cycle
//   with rsp_ch.ready high from the eight-entry queue. req_ch.ready drops while
//   a byte waits in the input register for five free queue entries.
// Reset: synchronous; the window, unit state and queue empty at once.
// Stall: a stalled receiver holds the head word; input continues until fewer
//   than five queue entries are free and a byte waits in the input register.
module annexb_nal_splitter
   import anbs_pkg::*;
#(
   parameter int MAX_UNIT_BYTES = DEF_MAX_UNIT_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   anbs_req_if.sink    req_ch,
   anbs_rsp_if.source  rsp_ch
);

   push_type push;
   logic     queue_room;

   anbs_parser #(
      .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_room (queue_room),
      .push       (push)
   );

   anbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_room (queue_room),
      .rsp_ch     (rsp_ch)
   );

endmodule

### hw/rtl/anbs_parser.sv
// Input register, start code window and per-byte word generation.
module anbs_parser
   import anbs_pkg::*;
#(
   parameter int MAX_UNIT_BYTES = DEF_MAX_UNIT_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   anbs_req_if.sink    req_ch,
   input  logic        queue_room,
   output push_type    push
);

   localparam int CNT_W = $clog2(MAX_UNIT_BYTES + 2);
   localparam logic [CNT_W:0]   CNT_SAT  = (CNT_W + 1)'(MAX_UNIT_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_UNIT_BYTES);

   logic             stage_valid_ff;
   logic [7:0]       stage_byte_ff;
   logic             stage_fe_ff;
   logic             advance;

   logic [HOLD_DEPTH-1:0][7:0] window_ff, window_in;
   logic [2:0]       hold_count_ff, hold_count_in;
   logic             inside_ff, inside_in;
   logic             first_ff, first_in;
   logic [CNT_W-1:0] unit_count_ff, unit_count_in;

   logic [HOLD_DEPTH-1:0]      zero;
   logic                       z2, z3, is_start, shift, base;
   logic [2:0]                 keep, n_emit, nhc;
   logic [HOLD_DEPTH-1:0][7:0] nw;
   logic [MAX_EMITS-1:0][7:0]  em_byte;
   logic [MAX_EMITS-1:0]       em_last;

   assign advance      = stage_valid_ff && queue_room;
   assign req_ch.ready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         stage_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         stage_byte_ff <= req_ch.data_byte;
         stage_fe_ff   <= req_ch.frame_end;
      end
   end

   // Window analysis and the list of words this byte releases
   always_comb begin
      logic [2:0] j;
      j = '0;
      for (int i = 0; i < HOLD_DEPTH; i++) zero[i] = (window_ff[i] == 8'h00);
      z2 = (hold_count_ff == 3'd2 && zero[1] && zero[0])
        || (hold_count_ff == 3'd3 && zero[2] && zero[1])
        || (hold_count_ff == 3'd4 && zero[3] && zero[2]);
      z3 = (hold_count_ff == 3'd3 && zero[2] && zero[1] && zero[0])
        || (hold_count_ff == 3'd4 && zero[3] && zero[2] && zero[1]);
      is_start = (stage_byte_ff == START_TAIL) && z2;
      keep     = hold_count_ff - 3'd2 - {2'b00, z3};
      shift    = (hold_count_ff == 3'd4);
      base     = shift && inside_ff;
      nhc      = shift ? 3'd4 : hold_count_ff + 3'd1;
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         if (shift) begin
            nw[i] = (i < HOLD_DEPTH - 1) ? window_ff[(i + 1) % HOLD_DEPTH] : stage_byte_ff;
         end else begin
            nw[i] = (3'(i) == hold_count_ff) ? stage_byte_ff : window_ff[i];
         end
      end
      em_byte = '0;
      em_last = '0;
      if (is_start) begin
         n_emit = inside_ff ? keep : 3'd0;
         for (int k = 0; k < 2; k++) begin
            em_byte[k] = window_ff[k];
            em_last[k] = (3'(k + 1) == keep);
         end
      end else begin
         n_emit = {2'b00, base} + ((stage_fe_ff && inside_ff) ? nhc : 3'd0);
         for (int k = 0; k < MAX_EMITS; k++) begin
            j = 3'(k) - {2'b00, base};
            if (k == 0 && base) begin
               em_byte[k] = window_ff[0];
               em_last[k] = 1'b0;
            end else begin
               em_byte[k] = nw[j[1:0]];
               em_last[k] = (j == nhc - 3'd1);
            end
         end
      end
   end

   // Running count per word, saturating above the maximum unit length
   always_comb begin
      logic [CNT_W:0]   sum;
      logic [CNT_W-1:0] cnt;
      logic [CNT_W-1:0] len;
      logic             ovf;
      push.count = advance ? n_emit : 3'd0;
      for (int k = 0; k < MAX_EMITS; k++) begin
         sum = {1'b0, unit_count_ff} + (CNT_W + 1)'(k + 1);
         cnt = (sum > CNT_SAT) ? CNT_SAT[CNT_W-1:0] : sum[CNT_W-1:0];
         ovf = (cnt > CNT_MAX);
         len = ovf ? CNT_MAX : cnt;
         push.item[k].nal_byte        = em_byte[k];
         push.item[k].nal_first       = (k == 0) && first_ff;
         push.item[k].nal_last        = em_last[k];
         push.item[k].length_overflow = ovf;
         if (!em_last[k]) begin
            push.item[k].nal_length = '0;
         end else if (32'(len) > 32'(LEN_FIELD_MAX)) begin
            push.item[k].nal_length = LEN_FIELD_MAX;
         end else begin
            push.item[k].nal_length = LEN_W'(len);
         end
      end
   end

   always_comb begin
      logic [CNT_W:0] total;
      window_in     = window_ff;
      hold_count_in = hold_count_ff;
      inside_in     = inside_ff;
      first_in      = first_ff;
      unit_count_in = unit_count_ff;
      total = {1'b0, unit_count_ff} + (CNT_W + 1)'(n_emit);
      if (advance) begin
         if (is_start) begin
            window_in     = '0;
            hold_count_in = 3'd0;
            inside_in     = !stage_fe_ff;
            first_in      = !stage_fe_ff;
            unit_count_in = '0;
         end else if (stage_fe_ff) begin
            window_in     = '0;
            hold_count_in = 3'd0;
            inside_in     = 1'b0;
            first_in      = 1'b0;
            unit_count_in = '0;
         end else begin
            window_in     = nw;
            hold_count_in = nhc;
            if (n_emit != 3'd0) first_in = 1'b0;
            unit_count_in = (total > CNT_SAT) ? CNT_SAT[CNT_W-1:0] : total[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         hold_count_ff <= 3'd0;
         inside_ff     <= 1'b0;
         first_ff      <= 1'b0;
         unit_count_ff <= '0;
      end else begin
         window_ff     <= window_in;
         hold_count_ff <= hold_count_in;
         inside_ff     <= inside_in;
         first_ff      <= first_in;
         unit_count_ff <= unit_count_in;
      end
   end

`ifndef SYNTH
   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      hold_count_ff <= 3'd4)
      else $error("hold window count beyond four bytes");
   a_no_emit_outside: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> push.count == 3'd0)
      else $error("words pushed outside a unit");
   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_fe_ff) |=> (hold_count_ff == 3'd0 && !inside_ff && !first_ff))
      else $error("state not cleared after frame end");
   a_first_once: assert property (@(posedge clock) disable iff (reset)
      (advance && !is_start && !stage_fe_ff && push.count != 3'd0) |=> !first_ff)
      else $error("first mark still pending after a word");
`endif

endmodule

### hw/rtl/anbs_queue.sv
// Result queue: takes up to five words a cycle, delivers one word a cycle while rsp_ch.ready is high.
module anbs_queue
   import anbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   output logic        queue_room,
   anbs_rsp_if.source  rsp_ch
);

   result_type        q_ff [QUEUE_DEPTH];
   result_type        q_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0] cnt_ff, cnt_in, fill_base;
   logic              pop;

   assign pop        = rsp_ch.valid && rsp_ch.ready;
   assign queue_room = (cnt_ff <= QCNT_W'(QUEUE_DEPTH - MAX_EMITS));
   assign fill_base  = cnt_ff - QCNT_W'(pop);
   assign cnt_in     = fill_base + QCNT_W'(push.count);

   // Shift on pop, then append the new words behind the survivors
   always_comb begin
      logic [QCNT_W-1:0] off;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            q_in[i] = q_ff[(i + 1) % QUEUE_DEPTH];
         end else begin
            q_in[i] = q_ff[i];
         end
         off = QCNT_W'(i) - fill_base;
         if (QCNT_W'(i) >= fill_base && off < QCNT_W'(push.count)) begin
            q_in[i] = push.item[off[2:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) q_ff[i] <= q_in[i];
   end

   assign rsp_ch.valid           = (cnt_ff != '0);
   assign rsp_ch.nal_byte        = q_ff[0].nal_byte;
   assign rsp_ch.nal_first       = q_ff[0].nal_first;
   assign rsp_ch.nal_last        = q_ff[0].nal_last;
   assign rsp_ch.nal_length      = q_ff[0].nal_length;
   assign rsp_ch.length_overflow = q_ff[0].length_overflow;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 3'd0 |-> queue_room)
      else $error("words pushed without room");
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && cnt_ff == QCNT_W'(1) && push.count == 3'd0) |=> !rsp_ch.valid)
      else $error("queue not empty after last word taken");
`endif

endmodule

### sim/tb_annexb_nal_splitter.sv
// Testbench for the Annex B NAL splitter: byte stream stimulus, unit payload prediction, checks.
module tb_annexb_nal_splitter
   import anbs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNIT_CAP    = DEF_MAX_UNIT_BYTES;
   localparam int HOLD_CYCLES = 80;
   localparam int TAIL_CYCLES = 16;
   localparam int RAND_ITEMS  = 80;
   localparam result_type NO_WORD = '0;

   typedef struct {
      logic [7:0] data;
      logic       fe;
      bit         fixed;
      int         nfix;
      result_type fix;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   anbs_req_if req_ch ();
   anbs_rsp_if rsp_ch ();

   annexb_nal_splitter #(
      .MAX_UNIT_BYTES (UNIT_CAP)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [7:0]  win [HOLD_DEPTH];
   int unsigned win_cnt;
   bit          in_unit;
   bit          first_pend;
   int unsigned unit_cnt;

   result_type nal_words_due [$];
   int  errors = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;
   int  rand_sent = 0;

   // leading byte, start codes of both forms, empty unit, kept extra zero, frame end on a start code
   row_type dir_rows [23] = '{
      '{8'h55, 1'b1, 1'b1, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, 0, NO_WORD},
      '{8'h01, 1'b0, 1'b1, 0, NO_WORD},
      '{8'hAA, 1'b0, 1'b1, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, 0, NO_WORD},
      '{8'h01, 1'b0, 1'b1, 1, '{8'hAA, 1'b1, 1'b1, 21'd1, 1'b0}},
      '{8'h00, 1'b0, 1'b1, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, 0, NO_WORD},
      '{8'h01, 1'b0, 1'b1, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, 0, NO_WORD},
      '{8'h01, 1'b0, 1'b0, 0, NO_WORD},
      '{8'hFF, 1'b0, 1'b0, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, 0, NO_WORD},
      '{8'hFF, 1'b0, 1'b0, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, 0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, 0, NO_WORD},
      '{8'h01, 1'b1, 1'b0, 0, NO_WORD}
   };

   function automatic void clear_state();
      for (int i = 0; i < HOLD_DEPTH; i++) win[i] = 8'h00;
      win_cnt    = 0;
      in_unit    = 1'b0;
      first_pend = 1'b0;
      unit_cnt   = 0;
   endfunction

   function automatic result_type nal_word(input logic [7:0] b, input bit last);
      result_type  w;
      int unsigned len;
      bit          ovf;
      if (unit_cnt <= UNIT_CAP) unit_cnt++;
      ovf = unit_cnt > UNIT_CAP;
      len = ovf ? UNIT_CAP : unit_cnt;
      if (len > LEN_FIELD_MAX) len = LEN_FIELD_MAX;
      w.nal_byte        = b;
      w.nal_first       = first_pend;
      w.nal_last        = last;
      w.nal_length      = last ? len[LEN_W-1:0] : '0;
      w.length_overflow = ovf;
      first_pend = 1'b0;
      return w;
   endfunction

   function automatic int split_byte(input logic [7:0] b, input logic fe,
                                     output result_type words [MAX_EMITS]);
      int n;
      int z;
      int drop;
      int keep;
      n = 0;
      z = 0;
      for (int i = 0; i < MAX_EMITS; i++) words[i] = NO_WORD;
      while (z < int'(win_cnt) && win[win_cnt-1-z] == 8'h00) z++;
      if (b == START_TAIL && z >= 2) begin
         if (in_unit) begin
            // drop the start code zeros, and one more zero of the long form
            drop = (z >= 3) ? 3 : 2;
            keep = win_cnt - drop;
            for (int i = 0; i < keep; i++) begin
               words[n] = nal_word(win[i], i + 1 == keep);
               n++;
            end
         end
         clear_state();
         in_unit    = 1'b1;
         first_pend = 1'b1;
         if (fe) clear_state();
         return n;
      end
      if (win_cnt >= HOLD_DEPTH) begin
         if (in_unit) begin
            words[n] = nal_word(win[0], 1'b0);
            n++;
         end
         for (int i = 0; i < HOLD_DEPTH - 1; i++) win[i] = win[i+1];
         win_cnt = HOLD_DEPTH - 1;
      end
      win[win_cnt] = b;
      win_cnt++;
      if (fe) begin
         if (in_unit) begin
            for (int i = 0; i < int'(win_cnt); i++) begin
               words[n] = nal_word(win[i], i + 1 == int'(win_cnt));
               n++;
            end
         end
         clear_state();
      end
      return n;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // offer one byte, return at the edge that accepts it
   task automatic push_byte(input logic [7:0] b, input logic fe);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.frame_end <= fe;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic feed(input logic [7:0] b, input logic fe);
      result_type words [MAX_EMITS];
      int n;
      push_byte(b, fe);
      n = split_byte(b, fe, words);
      for (int i = 0; i < n; i++) nal_words_due = {nal_words_due, words[i]};
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (nal_words_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] payload_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 8'h00;
      if (r == 3) return START_TAIL;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_start_code(ref logic [7:0] q [$]);
      int k;
      k = $urandom_range(0, 3);
      if (k == 3) q = {q, 8'h00};
      if (k >= 2) q = {q, 8'h00};
      q = {q, 8'h00, 8'h00, START_TAIL};
   endtask

   task automatic send_frame(ref logic [7:0] q [$]);
      for (int i = 0; i < q.size(); i++) feed(q[i], i == q.size() - 1);
   endtask

   // stimulus
   initial begin
      logic [7:0] q [$];
      result_type words [MAX_EMITS];
      int n;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.frame_end = 1'b0;
      clear_state();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         push_byte(dir_rows[r].data, dir_rows[r].fe);
         n = split_byte(dir_rows[r].data, dir_rows[r].fe, words);
         if (dir_rows[r].fixed) begin
            if (dir_rows[r].nfix > 0) nal_words_due = {nal_words_due, dir_rows[r].fix};
         end else begin
            for (int i = 0; i < n; i++) nal_words_due = {nal_words_due, words[i]};
         end
      end
      drain();

      // receiver holds off while the sender keeps offering words
      calm = 1'b1;
      hold_req = 1'b1;
      q = '{8'h00, 8'h00, START_TAIL};
      repeat (48) q = {q, 8'($urandom_range(1, 255))};
      send_frame(q);
      calm = 1'b0;
      drain();

      while (rand_sent < RAND_ITEMS) begin
         q = {};
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 5) == 0) begin
            // noise frame
            repeat ($urandom_range(1, 6)) q = {q, payload_byte()};
         end else begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) q = {q, 8'($urandom_range(0, 255))};
            repeat ($urandom_range(1, 3)) begin
               add_start_code(q);
               if ($urandom_range(0, 7) != 0)
                  repeat ($urandom_range(1, 8)) q = {q, payload_byte()};
            end
         end
         send_frame(q);
         rand_sent += q.size();
         if ($urandom_range(0, 7) == 0) drain();
      end
      calm = 1'b0;
      drain();

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int gap;
      result_type got;
      result_type due;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         gap = calm ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.nal_byte        = rsp_ch.nal_byte;
         got.nal_first       = rsp_ch.nal_first;
         got.nal_last        = rsp_ch.nal_last;
         got.nal_length      = rsp_ch.nal_length;
         got.length_overflow = rsp_ch.length_overflow;
         if (nal_words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word, byte %h", got.nal_byte));
         end else begin
            due = nal_words_due.pop_front();
            if (got.nal_byte !== due.nal_byte)
               report_mismatch($sformatf("nal_byte %h, want %h", got.nal_byte, due.nal_byte));
            if (got.nal_first !== due.nal_first)
               report_mismatch($sformatf("nal_first %b, want %b", got.nal_first,
                                         due.nal_first));
            if (got.nal_last !== due.nal_last)
               report_mismatch($sformatf("nal_last %b, want %b", got.nal_last, due.nal_last));
            if (got.nal_length !== due.nal_length)
               report_mismatch($sformatf("nal_length %0d, want %0d", got.nal_length,
                                         due.nal_length));
            if (got.length_overflow !== due.length_overflow)
               report_mismatch($sformatf("length_overflow %b, want %b",
                                         got.length_overflow, due.length_overflow));
         end
      end
   end

   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/anbs_pkg.sv
hw/rtl/anbs_ifs.sv
hw/rtl/anbs_parser.sv
hw/rtl/anbs_queue.sv
hw/rtl/annexb_nal_splitter.sv
sim/tb_annexb_nal_splitter.sv
